FILE: sv/irfr_pkg.sv
// irfr_pkg: shared types and constants for the imu reply frame receiver
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package irfr_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 32;
  localparam int unsigned SkipW      = 16;
  localparam int unsigned FrameBytes = 31;
  localparam int unsigned WordCount  = 7;
  localparam int unsigned PosW       = 5;
  localparam int unsigned WordIdxW   = $clog2(WordCount);
  localparam int unsigned FifoDepth  = 4;

  localparam int unsigned OutBits    = WordCount * WordW + SkipW + 1;
  localparam int unsigned OutDataW   = ((OutBits + ByteW - 1) / ByteW) * ByteW;

  localparam logic [PosW-1:0]  TrailHiPos = PosW'(FrameBytes - 2);
  localparam logic [SkipW-1:0] SkipMax    = {SkipW{1'b1}};

  typedef enum logic [2:0] {
    TK_SKIP,
    TK_HEADER,
    TK_DATA,
    TK_TRAIL_HI,
    TK_TRAIL_LO
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e         kind;
    logic [PosW-1:0]   pos;
    logic [ByteW-1:0]  data;
  } token_t;

endpackage

`default_nettype wire

FILE: sv/irfr_front.sv
// irfr_front: header hunt and byte classification into tokens
// depends on irfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module irfr_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_wr_en_i,
  input  wire [irfr_pkg::ByteW-1:0]   cfg_wr_data_i,
  input  wire                         byte_valid_i,
  output logic                        byte_ready_o,
  input  wire [irfr_pkg::ByteW-1:0]   byte_i,
  output logic                        tok_valid_o,
  input  wire                         tok_ready_i,
  output irfr_pkg::token_t            tok_o
);

  logic [irfr_pkg::ByteW-1:0] header_q;
  logic                       collecting_q, collecting_d;
  logic [irfr_pkg::PosW-1:0]  pos_q, pos_d;
  logic                       take;

  assign byte_ready_o = tok_ready_i;
  assign tok_valid_o  = byte_valid_i;
  assign take         = byte_valid_i && tok_ready_i;

  always_comb begin
    collecting_d = collecting_q;
    pos_d        = pos_q;
    tok_o.data   = byte_i;
    tok_o.pos    = pos_q;
    tok_o.kind   = irfr_pkg::TK_SKIP;
    if (!collecting_q) begin
      if (byte_i == header_q) begin
        tok_o.kind   = irfr_pkg::TK_HEADER;
        collecting_d = 1'b1;
        pos_d        = irfr_pkg::PosW'(1);
      end
    end else if (pos_q < irfr_pkg::TrailHiPos) begin
      tok_o.kind = irfr_pkg::TK_DATA;
      pos_d      = pos_q + irfr_pkg::PosW'(1);
    end else if (pos_q == irfr_pkg::TrailHiPos) begin
      tok_o.kind = irfr_pkg::TK_TRAIL_HI;
      pos_d      = pos_q + irfr_pkg::PosW'(1);
    end else begin
      tok_o.kind   = irfr_pkg::TK_TRAIL_LO;
      collecting_d = 1'b0;
      pos_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q     <= '0;
      collecting_q <= 1'b0;
      pos_q        <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        header_q <= cfg_wr_data_i;
      end
      if (take) begin
        collecting_q <= collecting_d;
        pos_q        <= pos_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/irfr_fifo.sv
// irfr_fifo: short token queue between front and back
// depends on irfr_pkg; DEPTH must be a power of two, at least 2
`timescale 1ns / 1ps
`default_nettype none

module irfr_fifo #(
  parameter int unsigned DEPTH = irfr_pkg::FifoDepth
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 wr_valid_i,
  output logic                wr_ready_o,
  input  irfr_pkg::token_t    wr_data_i,
  output logic                rd_valid_o,
  input  wire                 rd_ready_i,
  output irfr_pkg::token_t    rd_data_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  irfr_pkg::token_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CntFull);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_ready_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/irfr_back.sv
// irfr_back: sum, skip count, word capture and result register
// depends on irfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module irfr_back (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            tok_valid_i,
  output logic                           tok_ready_o,
  input  irfr_pkg::token_t               tok_i,
  output logic                           res_valid_o,
  input  wire                            res_ready_i,
  output logic [irfr_pkg::OutDataW-1:0]  res_data_o
);

  logic [irfr_pkg::WordW-1:0]    field_q [irfr_pkg::WordCount];
  logic [irfr_pkg::ByteW-1:0]    trail_hi_q;
  logic [irfr_pkg::SkipW-1:0]    skip_q;
  logic [irfr_pkg::WordW/2-1:0]  sum_q;
  logic                          out_valid_q;
  logic [irfr_pkg::OutDataW-1:0] out_data_q;
  logic                          take;
  logic                          sum_ok;
  logic [irfr_pkg::PosW-1:0]     pos_m1;
  logic [irfr_pkg::WordIdxW-1:0] widx;

  assign pos_m1 = tok_i.pos - irfr_pkg::PosW'(1);
  assign widx   = pos_m1[irfr_pkg::PosW-1:2];
  assign sum_ok = (sum_q == {trail_hi_q, tok_i.data});

  // only the final trailer byte needs room in the result register
  assign tok_ready_o = (tok_i.kind != irfr_pkg::TK_TRAIL_LO) || !out_valid_q || res_ready_i;
  assign take        = tok_valid_i && tok_ready_o;
  assign res_valid_o = out_valid_q;
  assign res_data_o  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      case (tok_i.kind)
        irfr_pkg::TK_DATA: begin
          field_q[widx] <= {field_q[widx][irfr_pkg::WordW-irfr_pkg::ByteW-1:0], tok_i.data};
        end
        irfr_pkg::TK_TRAIL_HI: begin
          trail_hi_q <= tok_i.data;
        end
        irfr_pkg::TK_TRAIL_LO: begin
          out_data_q <= {
            (irfr_pkg::OutDataW - irfr_pkg::OutBits)'(0),
            sum_ok, skip_q,
            field_q[6], field_q[5], field_q[4], field_q[3],
            field_q[2], field_q[1], field_q[0]
          };
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        case (tok_i.kind)
          irfr_pkg::TK_SKIP: begin
            if (skip_q != irfr_pkg::SkipMax) begin
              skip_q <= skip_q + irfr_pkg::SkipW'(1);
            end
          end
          irfr_pkg::TK_HEADER: begin
            sum_q <= {{(irfr_pkg::WordW/2-irfr_pkg::ByteW){1'b0}}, tok_i.data};
          end
          irfr_pkg::TK_DATA: begin
            sum_q <= sum_q + {{(irfr_pkg::WordW/2-irfr_pkg::ByteW){1'b0}}, tok_i.data};
          end
          irfr_pkg::TK_TRAIL_LO: begin
            out_valid_q <= 1'b1;
            sum_q       <= '0;
            skip_q      <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/imu_reply_frame_receiver.sv
// imu_reply_frame_receiver: top level, front classifier, token queue, back end
// depends on irfr_pkg, irfr_front, irfr_fifo, irfr_back
//
//   channel   dir  width  contents
//   s_axis    in   8      rx_byte
//   m_axis    out  248    one result per frame, packed fields
//   cfg       in   8      header_byte
//
// one byte is taken per cycle while the token queue has room; the last trailer
// byte passes through the token queue, then the result register sets m_axis valid.
// only the last trailer byte token waits on the output register; the input keeps
// going until the FIFO_DEPTH token queue fills behind it.
// reset clears state, header byte and skip count.
`timescale 1ns / 1ps
`default_nettype none

module imu_reply_frame_receiver #(
  parameter int unsigned FIFO_DEPTH = irfr_pkg::FifoDepth
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_wr_en_i,
  input  wire [irfr_pkg::ByteW-1:0]      cfg_wr_data_i,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire [irfr_pkg::ByteW-1:0]      s_axis_tdata,   // rx_byte
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, timestamp_ticks,
  // skipped_count, checksum_ok, zero fill
  output logic [irfr_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic             f_valid, f_ready, b_valid, b_ready;
  irfr_pkg::token_t f_tok, b_tok;

  irfr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .byte_valid_i  (s_axis_tvalid),
    .byte_ready_o  (s_axis_tready),
    .byte_i        (s_axis_tdata),
    .tok_valid_o   (f_valid),
    .tok_ready_i   (f_ready),
    .tok_o         (f_tok)
  );

  irfr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_tok),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_tok)
  );

  irfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (b_valid),
    .tok_ready_o (b_ready),
    .tok_i       (b_tok),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: verif/tb_imu_reply_frame_receiver.sv
// tb_imu_reply_frame_receiver: self-checking bench for the imu reply frame receiver
// streams header-hunted reply frames and noise bytes in, predicts each frame result
// and compares it field by field; depends on irfr_pkg and imu_reply_frame_receiver
`timescale 1ns / 1ps

module tb_imu_reply_frame_receiver;
  import irfr_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomBytes = 1600;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongSkipRun = 200;

  typedef logic [WordCount-1:0][WordW-1:0] word_set_t;

  typedef struct packed {
    logic             chk_ok;
    logic [SkipW-1:0] skips;
    word_set_t        words;
  } imu_sample_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_wr_en_i = 1'b0;
  logic [ByteW-1:0]     cfg_wr_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;

  imu_reply_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // frame parser model
  logic [ByteW-1:0] hdr_model = '0;
  logic             in_frame = 1'b0;
  logic [PosW-1:0]  frame_pos = '0;
  logic [15:0]      byte_sum = '0;
  logic [SkipW-1:0] skip_run = '0;
  word_set_t        word_acc = '0;
  logic [ByteW-1:0] trail_hi_q = '0;

  imu_sample_t pending_samples[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  bit          idle_en = 1'b1;

  string field_names[WordCount] = '{"accel_x", "accel_y", "accel_z", "rate_x", "rate_y",
                                     "rate_z", "timestamp_ticks"};

  function automatic void absorb_byte(input logic [ByteW-1:0] b);
    imu_sample_t s;
    int unsigned w;
    if (!in_frame) begin
      if (b == hdr_model) begin
        in_frame  = 1'b1;
        frame_pos = 1;
        byte_sum  = 16'(b);
      end else if (skip_run != SkipMax) begin
        skip_run++;
      end
    end else if (frame_pos < TrailHiPos) begin
      byte_sum += 16'(b);
      w = (frame_pos - 1) >> 2;
      word_acc[w] = {word_acc[w][WordW-ByteW-1:0], b};
      frame_pos++;
    end else if (frame_pos == TrailHiPos) begin
      trail_hi_q = b;
      frame_pos++;
    end else begin
      s.words  = word_acc;
      s.skips  = skip_run;
      s.chk_ok = (byte_sum == {trail_hi_q, b});
      pending_samples.push_back(s);
      in_frame  = 1'b0;
      frame_pos = '0;
      byte_sum  = '0;
      skip_run  = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // result checker and output stall
  always @(posedge clk_i) begin : result_check
    imu_sample_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[WordW-1:0], '0);
      end else begin
        want = pending_samples.pop_front();
        for (int i = 0; i < WordCount; i++)
          if (m_axis_tdata[i*WordW +: WordW] !== want.words[i])
            report_mismatch(field_names[i], m_axis_tdata[i*WordW +: WordW], want.words[i]);
        if (m_axis_tdata[WordCount*WordW +: SkipW] !== want.skips)
          report_mismatch("skipped_count", 32'(m_axis_tdata[WordCount*WordW +: SkipW]),
                          32'(want.skips));
        if (m_axis_tdata[WordCount*WordW+SkipW] !== want.chk_ok)
          report_mismatch("checksum_ok", 32'(m_axis_tdata[WordCount*WordW+SkipW]),
                          32'(want.chk_ok));
      end
    end
    m_axis_tready <= !(idle_en && $urandom_range(99) < 22);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while (idle_en && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_byte(b);
    bytes_sent++;
  endtask

  task automatic pause_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [ByteW-1:0] v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    hdr_model = v;
  endtask

  function automatic logic [ByteW-1:0] non_header_byte();
    logic [ByteW-1:0] b;
    do b = ByteW'($urandom_range(255)); while (b == hdr_model);
    return b;
  endfunction

  function automatic word_set_t rand_words();
    word_set_t w;
    for (int i = 0; i < WordCount; i++) w[i] = $urandom;
    return w;
  endfunction

  function automatic void build_frame(input logic [ByteW-1:0] hdr, input word_set_t w,
                                      input bit good, output logic [ByteW-1:0] fb[FrameBytes]);
    logic [15:0] sum;
    sum   = 16'(hdr);
    fb[0] = hdr;
    for (int i = 0; i < WordCount * 4; i++) begin
      fb[i+1] = w[i/4][WordW-1-8*(i%4) -: ByteW];
      sum += 16'(fb[i+1]);
    end
    if (!good) sum ^= 16'(1 + $urandom_range(16'hfffe));
    fb[FrameBytes-2] = sum[15:8];
    fb[FrameBytes-1] = sum[7:0];
  endfunction

  task automatic send_frame(input logic [ByteW-1:0] hdr, input word_set_t w, input bit good);
    logic [ByteW-1:0] fb[FrameBytes];
    build_frame(hdr, w, good, fb);
    for (int i = 0; i < FrameBytes; i++) send_byte(fb[i]);
  endtask

  // header register still at reset value
  task automatic test_reset_header();
    repeat (3) send_byte(non_header_byte());
    send_frame(hdr_model, rand_words(), 1'b1);
    send_frame(hdr_model, '0, 1'b1);
  endtask

  // all-zero and all-one payloads, header byte repeated inside the frame, bad sums
  task automatic test_field_extremes();
    pause_for_results();
    write_header(8'hFF);
    send_frame(8'hFF, '1, 1'b1);
    send_frame(8'hFF, '0, 1'b0);
    send_byte(8'h00);
    send_frame(8'hFF, rand_words(), 1'b0);
  endtask

  // header changes while a frame is half received
  task automatic test_header_mid_frame();
    logic [ByteW-1:0] fb[FrameBytes];
    pause_for_results();
    write_header(8'h5A);
    build_frame(8'h5A, rand_words(), 1'b1, fb);
    for (int i = 0; i < 15; i++) send_byte(fb[i]);
    pause_for_results();
    write_header(8'hA5);
    for (int i = 15; i < FrameBytes; i++) send_byte(fb[i]);
    send_byte(8'h5A);
    send_frame(8'hA5, rand_words(), 1'b1);
  endtask

  // long hunt with no idling, then the skip count clears after the frame
  task automatic test_long_skip_run();
    pause_for_results();
    write_header(8'h3C);
    idle_en = 1'b0;
    for (int i = 0; i < LongSkipRun; i++) send_byte(non_header_byte());
    send_frame(8'h3C, rand_words(), 1'b1);
    send_frame(8'h3C, rand_words(), 1'b0);
    idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    logic [ByteW-1:0] hdr;
    while (bytes_sent < RandomBytes) begin
      idle_en = !(bytes_sent >= 800 && bytes_sent < 1100);
      pick = $urandom_range(99);
      if (pick < 8) begin
        pause_for_results();
        case ($urandom_range(3))
          0:       hdr = 8'h00;
          1:       hdr = 8'hFF;
          default: hdr = ByteW'($urandom_range(255));
        endcase
        write_header(hdr);
      end else if (pick < 75) begin
        repeat ($urandom_range(3)) send_byte(non_header_byte());
        send_frame(hdr_model, rand_words(), $urandom_range(99) < 85);
      end else begin
        repeat (1 + $urandom_range(5)) send_byte(ByteW'($urandom_range(255)));
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_header();
    test_field_extremes();
    test_header_mid_frame();
    test_long_skip_run();
    test_random_traffic();
    pause_for_results();
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/irfr_pkg.sv
sv/irfr_front.sv
sv/irfr_fifo.sv
sv/irfr_back.sv
sv/imu_reply_frame_receiver.sv
verif/tb_imu_reply_frame_receiver.sv
